>>> hdl/zoh_pkg.sv
package zoh_pkg;

  localparam int unsigned AccWidth   = 18;
  localparam int unsigned RateWidth  = 16;
  localparam int unsigned GainWidth  = 9;
  localparam int unsigned SampWidth  = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned MaxResults = 48;
  localparam int unsigned CntWidth   = $clog2(MaxResults);

  localparam logic [CfgIdxW-1:0] CfgSourceRate = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOutputRate = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGain       = 2'd2;

  localparam logic [RateWidth-1:0] SourceRateRst = 16'd11025;
  localparam logic [RateWidth-1:0] OutputRateRst = 16'd22050;
  localparam logic [GainWidth-1:0] GainRst       = 9'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUB,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 sub;
    logic [RateWidth-1:0] operand;
  } acc_op_t;

endpackage

>>> hdl/zoh_acc_unit.sv
module zoh_acc_unit (
  input  logic signed [zoh_pkg::AccWidth-1:0] acc,
  input  zoh_pkg::acc_op_t                    op,
  output logic signed [zoh_pkg::AccWidth-1:0] result
);

  logic signed [zoh_pkg::AccWidth:0] acc_ext;
  logic signed [zoh_pkg::AccWidth:0] opd_ext;
  logic signed [zoh_pkg::AccWidth:0] sum;

  always_comb begin
    acc_ext = {acc[zoh_pkg::AccWidth-1], acc};
    opd_ext = {{(zoh_pkg::AccWidth + 1 - zoh_pkg::RateWidth){1'b0}}, op.operand};
    sum     = op.sub ? (acc_ext - opd_ext) : (acc_ext + opd_ext);
    if (sum[zoh_pkg::AccWidth] != sum[zoh_pkg::AccWidth-1]) begin
      result = sum[zoh_pkg::AccWidth] ? {1'b1, {(zoh_pkg::AccWidth-1){1'b0}}}
                                      : {1'b0, {(zoh_pkg::AccWidth-1){1'b1}}};
    end else begin
      result = sum[zoh_pkg::AccWidth-1:0];
    end
  end

endmodule

>>> hdl/zoh_scale.sv
module zoh_scale (
  input  logic                              clk,
  input  logic                              en,
  input  logic [zoh_pkg::SampWidth-1:0]     sample,
  input  logic [zoh_pkg::GainWidth-1:0]     gain,
  output logic [zoh_pkg::SampWidth-1:0]     scaled
);

  logic signed [zoh_pkg::SampWidth-1:0]                      centered;
  logic signed [zoh_pkg::GainWidth:0]                        gain_s;
  logic signed [zoh_pkg::SampWidth+zoh_pkg::GainWidth:0]     product;
  logic [zoh_pkg::SampWidth-1:0]                             scaled_r;
  logic [zoh_pkg::SampWidth-1:0]                             scaled_nxt;

  // The flooring shift by 8 keeps bits 15:8; adding the midpoint flips the top bit.
  always_comb begin
    centered   = {~sample[zoh_pkg::SampWidth-1], sample[zoh_pkg::SampWidth-2:0]};
    gain_s     = {1'b0, gain};
    product    = (zoh_pkg::SampWidth + zoh_pkg::GainWidth + 1)'(centered) *
                 (zoh_pkg::SampWidth + zoh_pkg::GainWidth + 1)'(gain_s);
    scaled_nxt = product[2*zoh_pkg::SampWidth-1:zoh_pkg::SampWidth] ^ 8'h80;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scaled_r <= scaled_nxt;
    end
  end

  assign scaled = scaled_r;

endmodule

>>> hdl/zoh_resampler_with_volume.sv
// The first output word is registered after its input word passes ST_SUB and ST_EMIT,
// and output backpressure can hold it. An input word yields 0 to 48 output words; one
// shared saturating accumulator adder does one step per cycle unless output
// backpressure holds it. Input is stalled while a word is in progress, also when
// backpressure holds it. Reset (synchronous, rst_n low) clears the accumulator and
// loads the default rates and unity gain.
module zoh_resampler_with_volume (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [zoh_pkg::SampWidth-1:0]     in_sample_in,
  input  logic                              in_first_of_sound,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [zoh_pkg::SampWidth-1:0]     out_sample_out,
  output logic                              out_last_of_run,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [zoh_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [zoh_pkg::RateWidth-1:0]     cfg_data
);

  zoh_pkg::state_t state_r, state_nxt;

  logic [zoh_pkg::RateWidth-1:0]        src_rate_r;
  logic [zoh_pkg::RateWidth-1:0]        out_rate_r;
  logic [zoh_pkg::GainWidth-1:0]        gain_r;
  logic signed [zoh_pkg::AccWidth-1:0]  acc_r, acc_nxt;
  logic [zoh_pkg::CntWidth-1:0]         cnt_r, cnt_nxt;
  logic                                 first_r;
  logic                                 out_valid_r, out_valid_nxt;
  logic [zoh_pkg::SampWidth-1:0]        out_sample_r, out_sample_nxt;
  logic                                 out_last_r, out_last_nxt;

  zoh_pkg::acc_op_t                     op;
  logic signed [zoh_pkg::AccWidth-1:0]  alu_result;
  logic [zoh_pkg::SampWidth-1:0]        scaled;
  logic                                 in_accept;
  logic                                 slot_free;
  logic                                 last_emit;

  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  zoh_acc_unit u_acc (
    .acc    (acc_r),
    .op     (op),
    .result (alu_result)
  );

  zoh_scale u_scale (
    .clk    (clk),
    .en     (in_accept),
    .sample (in_sample_in),
    .gain   (gain_r),
    .scaled (scaled)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rate_r <= zoh_pkg::SourceRateRst;
      out_rate_r <= zoh_pkg::OutputRateRst;
      gain_r     <= zoh_pkg::GainRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        zoh_pkg::CfgSourceRate: src_rate_r <= cfg_data;
        zoh_pkg::CfgOutputRate: out_rate_r <= cfg_data;
        zoh_pkg::CfgGain:       gain_r     <= cfg_data[zoh_pkg::GainWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    op.sub         = (state_r == zoh_pkg::ST_SUB);
    op.operand     = (state_r == zoh_pkg::ST_SUB) ? out_rate_r : src_rate_r;
    last_emit      = (!alu_result[zoh_pkg::AccWidth-1] && (alu_result != '0)) ||
                     (cnt_r == zoh_pkg::CntWidth'(zoh_pkg::MaxResults - 1));
    in_stall       = (state_r != zoh_pkg::ST_IDLE);
    case (state_r)
      zoh_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = zoh_pkg::ST_SUB;
        end
      end
      zoh_pkg::ST_SUB: begin
        acc_nxt = first_r ? '0 : alu_result;
        cnt_nxt = '0;
        if (!first_r && !alu_result[zoh_pkg::AccWidth-1] && (alu_result != '0)) begin
          state_nxt = zoh_pkg::ST_IDLE;
        end else begin
          state_nxt = zoh_pkg::ST_EMIT;
        end
      end
      zoh_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = scaled;
          out_last_nxt   = last_emit;
          acc_nxt        = alu_result;
          cnt_nxt        = cnt_r + zoh_pkg::CntWidth'(1);
          if (last_emit) begin
            state_nxt = zoh_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = zoh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zoh_pkg::ST_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      first_r <= in_first_of_sound;
    end
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_last_of_run = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == zoh_pkg::ST_EMIT |-> cnt_r < zoh_pkg::CntWidth'(zoh_pkg::MaxResults))
    else $error("emit count beyond limit");

  a_emit_acc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == zoh_pkg::ST_EMIT |-> (acc_r[zoh_pkg::AccWidth-1] || acc_r == '0))
    else $error("emitting with positive accumulator");

  a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> state_r == zoh_pkg::ST_EMIT)
    else $error("run ended without a last word");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == zoh_pkg::ST_SUB)
    else $error("accepted word not processed");

endmodule
